FILE: hdl/tmcw_pkg.sv
// ----------------------------------------------------------------------------
// tmcw_pkg
// Shared codes, constants and controller/datapath interface structs for the
// text-mode console writer.
// ----------------------------------------------------------------------------
`default_nettype none

package tmcw_pkg;

  typedef enum logic [2:0] {
    CMD_PUT_CHAR  = 3'd0,
    CMD_BACKSPACE = 3'd1,
    CMD_PUT_CELL  = 3'd2,
    CMD_SCROLL    = 3'd3,
    CMD_READ_CELL = 3'd4
  } cmd_e;

  // register index, taken from paddr[2]
  localparam logic REG_TEXT_COLOR = 1'b0;

  localparam logic [15:0] BLANK_CELL     = 16'h0720;
  localparam logic [7:0]  NEWLINE_CODE   = 8'h0A;
  localparam logic [7:0]  SPACE_CODE     = 8'h20;
  localparam logic [7:0]  TEXT_COLOR_RST = 8'h07;

  typedef struct packed {
    logic capture;
    logic clear_step;
    logic scroll_start;
    logic blank_step;
    logic wr_cell;
    logic rd_cell;
    logic finish;
  } ctl_cmd_t;

  typedef struct packed {
    logic clear_last;
    logic blank_last;
    logic wr_before;
    logic do_scroll;
    logic wr_after;
    logic rd_cell;
    logic out_free;
  } dp_stat_t;

endpackage

`default_nettype wire

FILE: hdl/tmcw_ctrl.sv
// ----------------------------------------------------------------------------
// tmcw_ctrl
// Sequencer: clearing pass after reset, then per word the write, row
// blanking, second write, read and result steps.
// ----------------------------------------------------------------------------
`default_nettype none

module tmcw_ctrl (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  input  wire tmcw_pkg::dp_stat_t stat_i,
  output tmcw_pkg::ctl_cmd_t      cmd_o
);
  import tmcw_pkg::*;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_PLAN,
    ST_WRITE1,
    ST_SCROLL,
    ST_BLANK,
    ST_WRITE2,
    ST_READ,
    ST_FINISH
  } state_e;

  state_e state_q, state_d;
  state_e after_wr1, after_scroll, after_wr2;
  logic   in_ready_q;

  assign after_wr2    = stat_i.rd_cell ? ST_READ : ST_FINISH;
  assign after_scroll = stat_i.wr_after ? ST_WRITE2 : after_wr2;
  assign after_wr1    = stat_i.do_scroll ? ST_SCROLL : after_scroll;

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_CLEAR:  if (stat_i.clear_last) state_d = ST_IDLE;
      ST_IDLE:   if (in_valid_i) state_d = ST_PLAN;
      ST_PLAN:   state_d = stat_i.wr_before ? ST_WRITE1 : after_wr1;
      ST_WRITE1: state_d = after_wr1;
      ST_SCROLL: state_d = ST_BLANK;
      ST_BLANK:  if (stat_i.blank_last) state_d = after_scroll;
      ST_WRITE2: state_d = after_wr2;
      ST_READ:   state_d = ST_FINISH;
      ST_FINISH: if (stat_i.out_free) state_d = ST_IDLE;
      default:   state_d = ST_CLEAR;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_CLEAR;
      in_ready_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      in_ready_q <= (state_d == ST_IDLE);
    end
  end

  assign in_ready_o = in_ready_q;

  always_comb begin
    cmd_o              = '0;
    cmd_o.capture      = (state_q == ST_IDLE) && in_valid_i;
    cmd_o.clear_step   = (state_q == ST_CLEAR);
    cmd_o.scroll_start = (state_q == ST_SCROLL);
    cmd_o.blank_step   = (state_q == ST_BLANK);
    cmd_o.wr_cell      = (state_q == ST_WRITE1) || (state_q == ST_WRITE2);
    cmd_o.rd_cell      = (state_q == ST_READ);
    cmd_o.finish       = (state_q == ST_FINISH) && stat_i.out_free;
  end

endmodule

`default_nettype wire

FILE: hdl/tmcw_datapath.sv
// ----------------------------------------------------------------------------
// tmcw_datapath
// Screen memory with rotating row base, cursor, scroll row counters and the
// result register.
// ----------------------------------------------------------------------------
`default_nettype none

module tmcw_datapath #(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 24
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire tmcw_pkg::ctl_cmd_t cmd_i,
  output tmcw_pkg::dp_stat_t      stat_o,
  input  wire logic [7:0]         text_color_i,
  input  wire logic [2:0]         command_i,
  input  wire logic [7:0]         char_code_i,
  input  wire logic [7:0]         cell_color_i,
  input  wire logic [6:0]         pos_column_i,
  input  wire logic [4:0]         pos_row_i,
  input  wire logic               scroll_down_i,
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  output logic [4:0]              cursor_row_now_o,
  output logic [6:0]              cursor_column_now_o,
  output logic [15:0]             cell_word_o,
  output logic                    did_scroll_o,
  output logic                    bad_position_o
);
  import tmcw_pkg::*;

  localparam int CW    = $clog2(COLUMNS);
  localparam int RW    = $clog2(ROWS);
  localparam int AW    = RW + CW;
  localparam int DEPTH = ROWS * (2 ** CW);

  localparam logic [CW-1:0] COL_LAST = CW'(COLUMNS - 1);
  localparam logic [RW-1:0] ROW_LAST = RW'(ROWS - 1);

  logic [2:0]    cmd_q;
  logic [7:0]    ch_q, color_q;
  logic [6:0]    pcol_q;
  logic [4:0]    prow_q;
  logic          dir_q;

  logic [RW-1:0] cur_row_q, cur_row_d;
  logic [CW-1:0] cur_col_q, cur_col_d;
  logic [RW-1:0] base_q;
  logic [RW-1:0] clr_row_q;
  logic [CW-1:0] clr_col_q;
  logic [RW-1:0] blank_row_q;
  logic [CW-1:0] blank_col_q;
  logic [15:0]   rdata_q;

  logic [15:0]   mem_q [DEPTH];

  logic          out_valid_q;
  logic [4:0]    out_row_q;
  logic [6:0]    out_col_q;
  logic [15:0]   out_cell_q;
  logic          out_scroll_q, out_bad_q;

  logic          on_screen, is_nl, col_end, row_end, col_zero, row_zero, adv;
  logic          wr_before, wr_after, do_scroll, scroll_up, rd_req, bad;
  logic [RW-1:0] t_row;
  logic [CW-1:0] t_col;
  logic [15:0]   wr_data;
  logic [RW:0]   row_sum;
  logic [RW-1:0] phys_row;
  logic [RW-1:0] base_up, base_dn;
  logic          we;
  logic [AW-1:0] waddr;
  logic [15:0]   wdata;

  assign on_screen = ({1'b0, pcol_q} < 8'(COLUMNS)) && ({1'b0, prow_q} < 6'(ROWS));
  assign is_nl     = (ch_q == NEWLINE_CODE);
  assign col_end   = (cur_col_q == COL_LAST);
  assign row_end   = (cur_row_q == ROW_LAST);
  assign col_zero  = (cur_col_q == '0);
  assign row_zero  = (cur_row_q == '0);
  assign adv       = is_nl || col_end;

  always_comb begin
    wr_before = 1'b0;
    wr_after  = 1'b0;
    do_scroll = 1'b0;
    scroll_up = 1'b0;
    rd_req    = 1'b0;
    bad       = 1'b0;
    cur_row_d = cur_row_q;
    cur_col_d = cur_col_q;
    t_row     = cur_row_q;
    t_col     = cur_col_q;
    wr_data   = {text_color_i, ch_q};
    case (cmd_q)
      CMD_PUT_CHAR: begin
        wr_before = !is_nl;
        do_scroll = adv && row_end;
        scroll_up = 1'b1;
        cur_col_d = adv ? '0 : cur_col_q + 1'b1;
        cur_row_d = (adv && !row_end) ? cur_row_q + 1'b1 : cur_row_q;
      end
      CMD_BACKSPACE: begin
        wr_after  = 1'b1;
        do_scroll = col_zero && row_zero;
        cur_col_d = col_zero ? COL_LAST : cur_col_q - 1'b1;
        cur_row_d = (col_zero && !row_zero) ? cur_row_q - 1'b1 : cur_row_q;
        t_row     = cur_row_d;
        t_col     = cur_col_d;
        wr_data   = {text_color_i, SPACE_CODE};
      end
      CMD_PUT_CELL: begin
        wr_before = on_screen;
        bad       = !on_screen;
        t_row     = RW'(prow_q);
        t_col     = CW'(pcol_q);
        wr_data   = {color_q, ch_q};
      end
      CMD_SCROLL: begin
        do_scroll = 1'b1;
        scroll_up = dir_q;
      end
      CMD_READ_CELL: begin
        rd_req = on_screen;
        bad    = !on_screen;
        t_row  = RW'(prow_q);
        t_col  = CW'(pcol_q);
      end
      default: begin
      end
    endcase
  end

  // logical row to physical row through the rotating base
  assign row_sum  = {1'b0, t_row} + {1'b0, base_q};
  assign phys_row = (row_sum >= (RW+1)'(ROWS)) ? RW'(row_sum - (RW+1)'(ROWS)) : RW'(row_sum);
  assign base_up  = (base_q == ROW_LAST) ? '0 : base_q + 1'b1;
  assign base_dn  = (base_q == '0) ? ROW_LAST : base_q - 1'b1;

  assign we = cmd_i.clear_step || cmd_i.blank_step || cmd_i.wr_cell;

  always_comb begin
    if (cmd_i.clear_step) begin
      waddr = {clr_row_q, clr_col_q};
      wdata = BLANK_CELL;
    end else if (cmd_i.blank_step) begin
      waddr = {blank_row_q, blank_col_q};
      wdata = BLANK_CELL;
    end else begin
      waddr = {phys_row, t_col};
      wdata = wr_data;
    end
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem_q[waddr] <= wdata;
    end
    if (cmd_i.rd_cell) begin
      rdata_q <= mem_q[{phys_row, t_col}];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      cmd_q   <= command_i;
      ch_q    <= char_code_i;
      color_q <= cell_color_i;
      pcol_q  <= pos_column_i;
      prow_q  <= pos_row_i;
      dir_q   <= scroll_down_i;
    end
    if (cmd_i.scroll_start) begin
      blank_row_q <= scroll_up ? base_q : base_dn;
    end
    if (cmd_i.finish) begin
      out_row_q    <= 5'(cur_row_d);
      out_col_q    <= 7'(cur_col_d);
      out_cell_q   <= rd_req ? rdata_q : 16'h0000;
      out_scroll_q <= do_scroll;
      out_bad_q    <= bad;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_row_q   <= '0;
      cur_col_q   <= '0;
      base_q      <= '0;
      clr_row_q   <= '0;
      clr_col_q   <= '0;
      blank_col_q <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.clear_step) begin
        if (clr_col_q == COL_LAST) begin
          clr_col_q <= '0;
          clr_row_q <= clr_row_q + 1'b1;
        end else begin
          clr_col_q <= clr_col_q + 1'b1;
        end
      end
      if (cmd_i.scroll_start) begin
        base_q      <= scroll_up ? base_up : base_dn;
        blank_col_q <= '0;
      end else if (cmd_i.blank_step) begin
        blank_col_q <= blank_col_q + 1'b1;
      end
      if (cmd_i.finish) begin
        cur_row_q   <= cur_row_d;
        cur_col_q   <= cur_col_d;
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_comb begin
    stat_o            = '0;
    stat_o.clear_last = (clr_row_q == ROW_LAST) && (clr_col_q == COL_LAST);
    stat_o.blank_last = (blank_col_q == COL_LAST);
    stat_o.wr_before  = wr_before;
    stat_o.do_scroll  = do_scroll;
    stat_o.wr_after   = wr_after;
    stat_o.rd_cell    = rd_req;
    stat_o.out_free   = !out_valid_q || out_ready_i;
  end

  assign out_valid_o         = out_valid_q;
  assign cursor_row_now_o    = out_row_q;
  assign cursor_column_now_o = out_col_q;
  assign cell_word_o         = out_cell_q;
  assign did_scroll_o        = out_scroll_q;
  assign bad_position_o      = out_bad_q;

endmodule

`default_nettype wire

FILE: hdl/text_mode_console_writer_core.sv
// Steps: a newline, an off-screen position or a spare command goes from the plan step straight
// to the result; a character, cell write, plain backspace or read adds a memory write or read;
// a scroll (command, line wrap off the bottom, backspace at top-left) adds a row-base step and a
// pass that blanks one row. One word at a time: the next word is taken once the result is
// registered, and a stalled result holds the sequencer before that point.
// Reset: cursor and row base clear at once; then a clearing pass blanks every on-screen cell.
// ----------------------------------------------------------------------------
// text_mode_console_writer_core
// Character-cell console: screen memory, cursor and APB color register.
// ----------------------------------------------------------------------------
`default_nettype none

module text_mode_console_writer_core #(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 24
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [2:0]  command_i,
  input  wire logic [7:0]  char_code_i,
  input  wire logic [7:0]  cell_color_i,
  input  wire logic [6:0]  pos_column_i,
  input  wire logic [4:0]  pos_row_i,
  input  wire logic        scroll_down_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [4:0]       cursor_row_now_o,
  output logic [6:0]       cursor_column_now_o,
  output logic [15:0]      cell_word_o,
  output logic             did_scroll_o,
  output logic             bad_position_o
);
  import tmcw_pkg::*;

  logic [7:0] text_color_q;
  ctl_cmd_t   ctl_cmd;
  dp_stat_t   dp_stat;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_TEXT_COLOR) ? {24'h000000, text_color_q} : 32'h0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      text_color_q <= TEXT_COLOR_RST;
    end else if (psel && penable && pwrite && (paddr[2] == REG_TEXT_COLOR)) begin
      text_color_q <= pwdata[7:0];
    end
  end

  tmcw_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .stat_i     (dp_stat),
    .cmd_o      (ctl_cmd)
  );

  tmcw_datapath #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
  ) u_datapath (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .cmd_i               (ctl_cmd),
    .stat_o              (dp_stat),
    .text_color_i        (text_color_q),
    .command_i           (command_i),
    .char_code_i         (char_code_i),
    .cell_color_i        (cell_color_i),
    .pos_column_i        (pos_column_i),
    .pos_row_i           (pos_row_i),
    .scroll_down_i       (scroll_down_i),
    .out_valid_o         (out_valid_o),
    .out_ready_i         (out_ready_i),
    .cursor_row_now_o    (cursor_row_now_o),
    .cursor_column_now_o (cursor_column_now_o),
    .cell_word_o         (cell_word_o),
    .did_scroll_o        (did_scroll_o),
    .bad_position_o      (bad_position_o)
  );

endmodule

`default_nettype wire

FILE: hdl/tmcw_checker.sv
// ----------------------------------------------------------------------------
// tmcw_checker
// Port-level checks on the console writer, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module tmcw_checker #(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 24
) (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        in_valid_i,
  input wire logic        in_ready_o,
  input wire logic        out_valid_o,
  input wire logic        out_ready_i,
  input wire logic [4:0]  cursor_row_now_o,
  input wire logic [6:0]  cursor_column_now_o,
  input wire logic [15:0] cell_word_o,
  input wire logic        did_scroll_o,
  input wire logic        bad_position_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("result word dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> $stable(cell_word_o) && $stable(cursor_row_now_o)
      && $stable(cursor_column_now_o))
    else $error("stalled result word changed");

  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("second word taken while busy");

  a_cursor_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> ({1'b0, cursor_column_now_o} < 8'(COLUMNS))
      && ({1'b0, cursor_row_now_o} < 6'(ROWS)))
    else $error("cursor off screen");

  a_bad_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (bad_position_o || did_scroll_o) |-> (cell_word_o == 16'h0000)
      && !(bad_position_o && did_scroll_o))
    else $error("flagged result carries cell data");

endmodule

bind text_mode_console_writer_core tmcw_checker #(
  .COLUMNS (COLUMNS),
  .ROWS    (ROWS)
) u_tmcw_checker (
  .clk_i               (clk_i),
  .rst_ni              (rst_ni),
  .in_valid_i          (in_valid_i),
  .in_ready_o          (in_ready_o),
  .out_valid_o         (out_valid_o),
  .out_ready_i         (out_ready_i),
  .cursor_row_now_o    (cursor_row_now_o),
  .cursor_column_now_o (cursor_column_now_o),
  .cell_word_o         (cell_word_o),
  .did_scroll_o        (did_scroll_o),
  .bad_position_o      (bad_position_o)
);

`default_nettype wire
